// File: rtl/core/i2a_pkg.sv
// Shared types and codes of the integer to padded ASCII formatter.
`timescale 1ns / 1ps
package i2a_pkg;
	localparam int VALUE_BITS = 32;
	localparam int MAX_FIELD = 63;
	localparam int DIGITS = 32;

	localparam logic [2:0] OP_BIN = 3'd0;
	localparam logic [2:0] OP_OCT = 3'd1;
	localparam logic [2:0] OP_SDEC = 3'd2;
	localparam logic [2:0] OP_UDEC = 3'd3;
	localparam logic [2:0] OP_LHEX = 3'd4;
	localparam logic [2:0] OP_UHEX = 3'd5;

	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_DEC = 2'd2;
	localparam logic [1:0] BASE_HEX = 2'd3;

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic emit;
	} i2a_cmd_t;

	typedef struct packed {
		logic dec_in;
		logic dec_q;
		logic div_done;
		logic last_taken;
	} i2a_sts_t;
endpackage

// File: rtl/core/i2a_ctrl.sv
// Controller state machine of the formatter: load, digit division, emit.
`timescale 1ns / 1ps
module i2a_ctrl
	import i2a_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  i2a_sts_t sts,
	output i2a_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL = 2'd1;
	localparam logic [1:0] S_DIV = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = sts.dec_in ? S_MUL : S_DIV;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_d = S_EMIT;
				end else begin
					state_d = sts.dec_q ? S_MUL : S_DIV;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.last_taken) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/core/i2a_dp.sv
// Datapath of the formatter: digit division, digit store, character pipeline.
`timescale 1ns / 1ps
module i2a_dp
	import i2a_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2a_cmd_t              cmd,
	output i2a_sts_t              sts,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [2:0]            opcode,
	input  logic [5:0]            field_width,
	input  logic                  left_adjust,
	input  logic                  zero_pad,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            char_code,
	output logic                  last
);
	localparam logic [31:0] DEC_RECIP = 32'hCCCCCCCD;
	localparam int DEC_SHIFT = 35;
	localparam logic [1:0] K_SPACE = 2'd0;
	localparam logic [1:0] K_ZERO = 2'd1;
	localparam logic [1:0] K_MINUS = 2'd2;
	localparam logic [1:0] K_DIGIT = 2'd3;

	logic [3:0]            mem [DIGITS];
	logic [VALUE_BITS-1:0] q_q;
	logic [63:0]           prod_q;
	logic [5:0]            nd_q;
	logic [1:0]            base_q;
	logic                  neg_q;
	logic                  upper_q;
	logic [5:0]            width_q;
	logic                  ladj_q;
	logic                  zpad_q;
	logic [5:0]            pos_q;
	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic                  last_s1;
	logic [3:0]            rd_data_s1;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic [1:0]            base_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] dec_quot;
	logic [VALUE_BITS-1:0] dec_rem;
	logic [3:0]            digit;
	logic [5:0]            len;
	logic [5:0]            total;
	logic [5:0]            pad;
	logic [5:0]            rd_pos;
	logic [1:0]            kind;
	logic                  advance;
	logic                  issue;
	logic [7:0]            char_d;

	always_comb begin
		unique case (opcode) inside
			OP_BIN: base_in = BASE_BIN;
			OP_OCT: base_in = BASE_OCT;
			OP_LHEX, OP_UHEX: base_in = BASE_HEX;
			default: base_in = BASE_DEC;
		endcase
	end
	assign neg_in = (opcode == OP_SDEC) && value[VALUE_BITS-1];

	assign dec_quot = {3'b000, prod_q[63:DEC_SHIFT]};
	assign dec_rem = q_q - ((dec_quot << 3) + (dec_quot << 1));

	always_comb begin
		unique case (base_q)
			BASE_BIN: begin
				quot = q_q >> 1;
				digit = {3'b000, q_q[0]};
			end
			BASE_OCT: begin
				quot = q_q >> 3;
				digit = {1'b0, q_q[2:0]};
			end
			BASE_HEX: begin
				quot = q_q >> 4;
				digit = q_q[3:0];
			end
			default: begin
				quot = dec_quot;
				digit = dec_rem[3:0];
			end
		endcase
	end

	assign sts.dec_in = (base_in == BASE_DEC);
	assign sts.dec_q = (base_q == BASE_DEC);
	assign sts.div_done = (quot == '0) || (nd_q == 6'(DIGITS - 1));
	assign sts.last_taken = out_valid_q && out_ready && out_last_q;

	assign len = nd_q + {5'd0, neg_q};
	assign total = (width_q > len) ? width_q : len;
	assign pad = total - len;

	always_comb begin
		rd_pos = total - 6'd1 - pos_q;
		if (ladj_q) begin
			rd_pos = len - 6'd1 - pos_q;
			if (neg_q && pos_q == 6'd0) begin
				kind = K_MINUS;
			end else if (pos_q < len) begin
				kind = K_DIGIT;
			end else begin
				kind = K_SPACE;
			end
		end else if (zpad_q) begin
			if (neg_q && pos_q == 6'd0) begin
				kind = K_MINUS;
			end else if (pos_q < pad + {5'd0, neg_q}) begin
				kind = K_ZERO;
			end else begin
				kind = K_DIGIT;
			end
		end else begin
			if (pos_q < pad) begin
				kind = K_SPACE;
			end else if (neg_q && pos_q == pad) begin
				kind = K_MINUS;
			end else begin
				kind = K_DIGIT;
			end
		end
	end

	assign advance = !out_valid_q || out_ready;
	assign issue = cmd.emit && advance && (pos_q != total);

	always_comb begin
		case (kind_s1)
			K_SPACE: char_d = 8'h20;
			K_ZERO: char_d = 8'h30;
			K_MINUS: char_d = 8'h2D;
			default: begin
				if (rd_data_s1 <= 4'd9) begin
					char_d = 8'h30 + {4'd0, rd_data_s1};
				end else begin
					char_d = (upper_q ? 8'h41 : 8'h61) + {4'd0, rd_data_s1} - 8'd10;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			mem[nd_q[4:0]] <= digit;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_pos[4:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_in;
			neg_q <= neg_in;
			upper_q <= (opcode == OP_UHEX);
			width_q <= field_width;
			ladj_q <= left_adjust;
			zpad_q <= zero_pad;
		end
		if (cmd.mul) begin
			prod_q <= {32'd0, q_q} * {32'd0, DEC_RECIP};
		end
		if (issue) begin
			kind_s1 <= kind;
			last_s1 <= (pos_q == total - 6'd1);
		end
		if (advance && valid_s1) begin
			out_char_q <= char_d;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
			nd_q <= '0;
			pos_q <= '0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				q_q <= neg_in ? (~value + 1'b1) : value;
				nd_q <= '0;
				pos_q <= '0;
			end
			if (cmd.div) begin
				q_q <= quot;
				nd_q <= nd_q + 6'd1;
			end
			if (issue) begin
				pos_q <= pos_q + 6'd1;
			end
			if (advance) begin
				valid_s1 <= issue;
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = out_char_q;
	assign last = out_last_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pos_q <= total)
		else $error("emit position ran past the field length");
	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |-> nd_q < 6'(DIGITS))
		else $error("digit store overflow");
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !valid_s1)
		else $error("character queued behind the last one");
	a_issue_emit: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> valid_s1)
		else $error("issued position lost in the read stage");
endmodule

// File: rtl/core/integer_to_padded_ascii.sv
// Top level of the integer to padded ASCII formatter.
// Usage:
//   Input channel (in_valid/in_ready) takes one request: a 32-bit value, a
//   conversion opcode, a field width, left_adjust and zero_pad flags.
//   Output channel (out_valid/out_ready) returns the field one character at a
//   time, most significant first, with last set on the final character.
//   in_ready is high only while no request is in work.
//   Steps per request: one load, then one division step per digit for binary,
//   octal and hex, a reciprocal multiply and then a remainder step per digit
//   for decimal, then one character per cycle while the receiver is ready,
//   through a two-stage read pipeline on the digit store.
//   When the receiver stalls, the output register holds its character and
//   the read pipeline freezes; no character is lost or repeated.
//   Reset clears the controller, the output valid and the digit counters;
//   the digit store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module integer_to_padded_ascii
	import i2a_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [2:0]            opcode,
	input  logic [5:0]            field_width,
	input  logic                  left_adjust,
	input  logic                  zero_pad,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            char_code,
	output logic                  last
);
	i2a_cmd_t cmd;
	i2a_sts_t sts;

	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2a_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.opcode      (opcode),
		.field_width (field_width),
		.left_adjust (left_adjust),
		.zero_pad    (zero_pad),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_code   (char_code),
		.last        (last)
	);
endmodule

// File: tb/integer_to_padded_ascii_check.sv
// Checker that predicts the formatted characters of each request and compares them.
`timescale 1ns / 1ps
module integer_to_padded_ascii_check
	import i2a_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [2:0]            opcode,
	input  logic [5:0]            field_width,
	input  logic                  left_adjust,
	input  logic                  zero_pad,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [7:0]            char_code,
	input  logic                  last,
	output int                    errors,
	output int                    pending
);
	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} char_rec_t;

	localparam logic [7:0] ASCII_ZERO    = "0";
	localparam logic [7:0] ASCII_LOWER_A = "a";
	localparam logic [7:0] ASCII_UPPER_A = "A";
	localparam logic [7:0] ASCII_MINUS   = "-";
	localparam logic [7:0] ASCII_SPACE   = " ";

	char_rec_t expected_chars[$];
	char_rec_t want;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
		if (d <= 4'd9)
			return ASCII_ZERO + d;
		return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + (d - 4'd10);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic predict_field(input logic [31:0] raw, input logic [2:0] op,
			input logic [5:0] width_in, input logic ladj, input logic zpad);
		logic [3:0] dg [DIGITS];
		logic [31:0] q;
		int unsigned base, nd, len, total, pad, width, pos;
		logic upper, neg;
		logic [7:0] c;
		upper = 1'b0;
		neg = 1'b0;
		q = raw;
		nd = 0;
		case (op)
		OP_BIN: base = 2;
		OP_OCT: base = 8;
		OP_SDEC: begin
			base = 10;
			if (raw[VALUE_BITS-1]) begin
				neg = 1'b1;
				q = -raw;
			end
		end
		OP_LHEX: base = 16;
		OP_UHEX: begin
			base = 16;
			upper = 1'b1;
		end
		default: base = 10;
		endcase
		do begin
			dg[nd] = 4'(q % base);
			q = q / base;
			nd++;
		end while (q != 0 && nd < DIGITS);
		width = width_in;
		if (width > MAX_FIELD)
			width = MAX_FIELD;
		len = nd + neg;
		total = (width > len) ? width : len;
		pad = total - len;
		for (pos = 0; pos < total; pos++) begin
			if (ladj) begin
				if (neg && pos == 0)
					c = ASCII_MINUS;
				else if (pos < len)
					c = digit_ascii(dg[len - 1 - pos], upper);
				else
					c = ASCII_SPACE;
			end else if (zpad) begin
				if (neg && pos == 0)
					c = ASCII_MINUS;
				else if (pos < pad + neg)
					c = ASCII_ZERO;
				else
					c = digit_ascii(dg[total - 1 - pos], upper);
			end else begin
				if (pos < pad)
					c = ASCII_SPACE;
				else if (neg && pos == pad)
					c = ASCII_MINUS;
				else
					c = digit_ascii(dg[total - 1 - pos], upper);
			end
			expected_chars.push_back('{c, (pos + 1 == total)});
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %h last %b", char_code, last));
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code)
						report_mismatch($sformatf("char_code got %h want %h",
							char_code, want.code));
					if (last !== want.fin)
						report_mismatch($sformatf("last got %b want %b on char %h",
							last, want.fin, want.code));
				end
			end
			if (in_valid && in_ready)
				predict_field(value, opcode, field_width, left_adjust, zero_pad);
			pending <= expected_chars.size();
		end
	end
endmodule

// File: tb/integer_to_padded_ascii_test.sv
// Top of the integer to padded ASCII formatter testbench: stimulus and verdict.
`timescale 1ns / 1ps
module integer_to_padded_ascii_test;
	import i2a_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int RANDOM_REQUESTS = 450;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 120;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] value;
	logic [2:0]            opcode;
	logic [5:0]            field_width;
	logic                  left_adjust;
	logic                  zero_pad;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            char_code;
	logic                  last;

	int errors;
	int pending;
	int idle_cycles = 0;
	int ready_run = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	integer_to_padded_ascii u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.opcode     (opcode),
		.field_width(field_width),
		.left_adjust(left_adjust),
		.zero_pad   (zero_pad),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.last       (last)
	);

	integer_to_padded_ascii_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.opcode     (opcode),
		.field_width(field_width),
		.left_adjust(left_adjust),
		.zero_pad   (zero_pad),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.last       (last),
		.errors     (errors),
		.pending    (pending)
	);

	always @(posedge clk) begin
		int pick;
		if (ready_run == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				out_ready <= 1'b0;
				ready_run = $urandom_range(1, 6);
			end else if (pick < 9) begin
				out_ready <= 1'b1;
				ready_run = $urandom_range(1, 12);
			end else begin
				out_ready <= 1'b1;
				ready_run = $urandom_range(40, 120);
			end
		end else begin
			ready_run--;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(input logic [31:0] v, input logic [2:0] op,
			input logic [5:0] w, input logic la, input logic zp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		value <= v;
		opcode <= op;
		field_width <= w;
		left_adjust <= la;
		zero_pad <= zp;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic random_request();
		logic [31:0] v;
		logic [5:0] w;
		int kind;
		kind = $urandom_range(0, 5);
		case (kind)
		0: v = $urandom();
		1: v = $urandom_range(0, 40);
		2: v = -$urandom_range(1, 40);
		3: begin
			case ($urandom_range(0, 3))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = 32'h8000_0000;
			default: v = 32'h7FFF_FFFF;
			endcase
		end
		4: v = $urandom() >> $urandom_range(0, 31);
		default: v = $urandom() | 32'h8000_0000;
		endcase
		case ($urandom_range(0, 9))
		0: w = 6'd0;
		1: w = 6'd63;
		2: w = 6'($urandom_range(33, 63));
		default: w = 6'($urandom_range(0, 24));
		endcase
		send_request(v, 3'($urandom_range(0, 7)), w, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		opcode = OP_BIN;
		field_width = '0;
		left_adjust = 1'b0;
		zero_pad = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(32'd0,         OP_UDEC,   6'd0,  1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, OP_BIN,    6'd63, 1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, OP_BIN,    6'd0,  1'b1, 1'b1);
		send_request(32'h8000_0000, OP_SDEC,   6'd0,  1'b0, 1'b0);
		send_request(32'h8000_0000, OP_SDEC,   6'd20, 1'b0, 1'b1);
		send_request(32'hFFFF_FFFF, OP_SDEC,   6'd6,  1'b0, 1'b0);
		send_request(32'hFFFF_FFF9, OP_SDEC,   6'd8,  1'b1, 1'b1);
		send_request(32'h7FFF_FFFF, OP_SDEC,   6'd63, 1'b1, 1'b0);
		send_request(32'h7FFF_FFFF, OP_SDEC,   6'd3,  1'b0, 1'b1);
		send_request(32'hFFFF_FFFF, OP_UDEC,   6'd0,  1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, OP_OCT,    6'd15, 1'b0, 1'b1);
		send_request(32'h0123_4567, OP_OCT,    6'd0,  1'b1, 1'b0);
		send_request(32'hDEAD_BEEF, OP_LHEX,   6'd12, 1'b0, 1'b1);
		send_request(32'hDEAD_BEEF, OP_UHEX,   6'd12, 1'b0, 1'b0);
		send_request(32'hCAFE_F00D, OP_UHEX,   6'd10, 1'b1, 1'b0);
		send_request(32'hABCD_EF09, OP_LHEX,   6'd0,  1'b0, 1'b0);
		send_request(32'd12345,     OP_SPARE6, 6'd8,  1'b0, 1'b1);
		send_request(32'hFFFF_FFFF, OP_SPARE7, 6'd63, 1'b1, 1'b1);
		send_request(32'd0,         OP_SDEC,   6'd63, 1'b0, 1'b1);
		send_request(32'd0,         OP_BIN,    6'd1,  1'b1, 1'b0);
		send_request(32'd0,         OP_LHEX,   6'd5,  1'b0, 1'b0);
		send_request(32'd1,         OP_BIN,    6'd63, 1'b0, 1'b1);
		send_request(32'hAAAA_AAAA, OP_BIN,    6'd40, 1'b1, 1'b1);
		send_request(32'h5555_5555, OP_UDEC,   6'd33, 1'b0, 1'b0);

		repeat (RANDOM_REQUESTS) random_request();

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
